// ===== rtl/md5_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared constants and helper functions of the MD5 digest unit: initial
// chaining words, round constants, rotate amounts and message word order.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hefcdab89;
    localparam logic [31:0] H2_INIT = 32'h98badcfe;
    localparam logic [31:0] H3_INIT = 32'h10325476;

    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam logic [7:0]  PAD_ZERO    = 8'h00;
    localparam logic [5:0]  PAD_STOP    = 6'd56;
    localparam logic [5:0]  LAST_BYTE   = 6'd63;
    localparam logic [5:0]  LAST_ROUND  = 6'd63;
    localparam logic [3:0]  LEN_LO_WORD = 4'd14;
    localparam logic [3:0]  LEN_HI_WORD = 4'd15;
    localparam logic [2:0]  MAX_BYTES   = 3'd4;
    localparam logic [1:0]  LAST_WORD   = 2'd3;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amount by phase and round-within-group
    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // message word used by each round, all arithmetic mod 16
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] g;
        r4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = r4;
            2'd1:    g = (r4 << 2) + r4 + 4'd1;
            2'd2:    g = (r4 << 1) + r4 + 4'd5;
            2'd3:    g = (r4 << 3) - r4;
            default: g = r4;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/md5_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_round
// One MD5 step: round function, constant and message add, rotate, add B.
// ----------------------------------------------------------------------------
module md5_round (
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [31:0] i_c,
    input  wire logic [31:0] i_d,
    input  wire logic [31:0] i_msg,
    input  wire logic [5:0]  i_rnd,
    output logic      [31:0] o_new_b
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  s;
    logic [63:0] dbl;

    always_comb begin
        case (i_rnd[5:4])
            2'd0:    f = (i_b & i_c) | (~i_b & i_d);
            2'd1:    f = (i_b & i_d) | (i_c & ~i_d);
            2'd2:    f = i_b ^ i_c ^ i_d;
            2'd3:    f = i_c ^ (i_b | ~i_d);
            default: f = i_b ^ i_c ^ i_d;
        endcase
    end

    assign sum     = i_a + f + md5_pkg::ROUND_CONST[i_rnd] + i_msg;
    assign s       = md5_pkg::rot_amount(i_rnd);
    // rotate left: upper half of the doubled word shifted
    assign dbl     = {sum, sum} << s;
    assign o_new_b = i_b + dbl[63:32];

endmodule
`default_nettype wire

// ===== rtl/md5_message_digest_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// Streaming MD5 engine with one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Message bytes come in as requests of up to four bytes, packed little-endian
// (first byte in bits 7:0). The unit takes one request at a time: o_ready is
// high only while it waits for one. Once a request is accepted, its bytes go
// into the 16-word block buffer one at a time at the running byte position.
// Every 64th byte starts a compression: the rounds run through the single
// round unit, one round per cycle, and then the working words are folded
// into the chaining words. When the 64th byte was the last of its request,
// the unit passes through the byte state once more to pick the request back
// up. On a request with message end the unit pads byte by byte (0x80, then
// zeros up to byte 56, plus a compression if the block wraps), checks that
// the pad is done, writes both words of the 64-bit bit length at once, runs
// the last compression and offers the digest as four requests, A to D, with
// o_final_word on D. After D is taken the chaining words and length return
// to their initial values. A byte count above four is treated as four;
// bytes above the count are ignored. The block buffer has no reset: every
// word is written before use.
// ----------------------------------------------------------------------------
module md5_message_digest_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_message_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [31:0] o_digest_word,
    output logic      [1:0]  o_word_number,
    output logic             o_final_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } t_state;

    // where to go once a compression has been folded in
    typedef enum logic [1:0] {
        RET_BYTE,
        RET_PAD,
        RET_LAST
    } t_ret;

    t_state      r_state;
    t_ret        r_ret;

    logic [31:0] r_h [4];       // chaining words A..D
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_rnd;
    logic [63:0] r_len;         // message length in bits, wraps
    logic [31:0] r_data;
    logic [2:0]  r_cnt;
    logic [2:0]  r_k;           // next byte of the held request
    logic        r_end;
    logic [5:0]  r_pos;         // byte position while padding
    logic        r_first;       // next pad byte is the 0x80 mark
    logic [1:0]  r_idx;

    logic [31:0] r_buf [16];    // block buffer, no reset

    logic        w_byte_en;
    logic        w_len_en;
    logic [5:0]  w_pos;
    logic [7:0]  w_byte;
    logic [31:0] w_msg;
    logic [31:0] w_new_b;
    logic        w_pad_done;

    // ------------------------------------------------------------------
    // Byte and length writer into the block buffer
    // ------------------------------------------------------------------
    assign w_pad_done = !r_first && (r_pos == md5_pkg::PAD_STOP);
    assign w_byte_en  = ((r_state == S_BYTE) && (r_k != r_cnt)) ||
                        ((r_state == S_PAD) && !w_pad_done);
    assign w_len_en   = (r_state == S_LEN);
    assign w_pos      = (r_state == S_BYTE) ? r_len[8:3] : r_pos;

    always_comb begin
        if (r_state == S_BYTE) begin
            w_byte = r_data[{r_k[1:0], 3'b000} +: 8];
        end else if (r_first) begin
            w_byte = md5_pkg::PAD_MARK;
        end else begin
            w_byte = md5_pkg::PAD_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_byte_en) begin
            r_buf[w_pos[5:2]][{w_pos[1:0], 3'b000} +: 8] <= w_byte;
        end
        if (w_len_en) begin
            r_buf[md5_pkg::LEN_LO_WORD] <= r_len[31:0];
            r_buf[md5_pkg::LEN_HI_WORD] <= r_len[63:32];
        end
    end

    // ------------------------------------------------------------------
    // Shared round unit
    // ------------------------------------------------------------------
    assign w_msg = r_buf[md5_pkg::msg_index(r_rnd)];

    md5_round u_round (
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .i_msg   (w_msg),
        .i_rnd   (r_rnd),
        .o_new_b (w_new_b)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= RET_BYTE;
            r_h[0]  <= md5_pkg::H0_INIT;
            r_h[1]  <= md5_pkg::H1_INIT;
            r_h[2]  <= md5_pkg::H2_INIT;
            r_h[3]  <= md5_pkg::H3_INIT;
            r_len   <= '0;
            r_rnd   <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_end   <= 1'b0;
            r_pos   <= '0;
            r_first <= 1'b0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_data  <= i_data_word;
                        r_cnt   <= (i_byte_count > md5_pkg::MAX_BYTES) ?
                                   md5_pkg::MAX_BYTES : i_byte_count;
                        r_end   <= i_message_end;
                        r_k     <= '0;
                        r_state <= S_BYTE;
                    end
                end
                S_BYTE: begin
                    if (r_k == r_cnt) begin
                        // request used up (or empty, or back from a block)
                        if (r_end) begin
                            r_pos   <= r_len[8:3];
                            r_first <= 1'b1;
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_len <= r_len + 64'd8;
                        r_k   <= r_k + 3'd1;
                        if (r_len[8:3] == md5_pkg::LAST_BYTE) begin
                            r_ret   <= RET_BYTE;
                            r_a     <= r_h[0];
                            r_b     <= r_h[1];
                            r_c     <= r_h[2];
                            r_d     <= r_h[3];
                            r_rnd   <= '0;
                            r_state <= S_ROUND;
                        end else if (r_k + 3'd1 == r_cnt) begin
                            if (r_end) begin
                                r_pos   <= r_len[8:3] + 6'd1;
                                r_first <= 1'b1;
                                r_state <= S_PAD;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_PAD: begin
                    if (w_pad_done) begin
                        r_state <= S_LEN;
                    end else begin
                        r_first <= 1'b0;
                        r_pos   <= r_pos + 6'd1;
                        if (r_pos == md5_pkg::LAST_BYTE) begin
                            r_ret   <= RET_PAD;
                            r_a     <= r_h[0];
                            r_b     <= r_h[1];
                            r_c     <= r_h[2];
                            r_d     <= r_h[3];
                            r_rnd   <= '0;
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_LEN: begin
                    r_ret   <= RET_LAST;
                    r_a     <= r_h[0];
                    r_b     <= r_h[1];
                    r_c     <= r_h[2];
                    r_d     <= r_h[3];
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_a   <= r_d;
                    r_b   <= w_new_b;
                    r_c   <= r_b;
                    r_d   <= r_c;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == md5_pkg::LAST_ROUND) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    case (r_ret)
                        RET_BYTE: r_state <= S_BYTE;
                        RET_PAD:  r_state <= S_PAD;
                        RET_LAST: begin
                            r_idx   <= '0;
                            r_state <= S_EMIT;
                        end
                        default:  r_state <= S_IDLE;
                    endcase
                end
                S_EMIT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == md5_pkg::LAST_WORD) begin
                            r_h[0]  <= md5_pkg::H0_INIT;
                            r_h[1]  <= md5_pkg::H1_INIT;
                            r_h[2]  <= md5_pkg::H2_INIT;
                            r_h[3]  <= md5_pkg::H3_INIT;
                            r_len   <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ports: combinational, all derived from registers
    // ------------------------------------------------------------------
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_EMIT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_number = r_idx;
    assign o_final_word  = (r_idx == md5_pkg::LAST_WORD);

endmodule
`default_nettype wire

// ===== rtl/md5_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_checker
// Port-level checks of the MD5 digest unit, bound to the top level.
// ----------------------------------------------------------------------------
module md5_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_digest_word,
    input wire logic [1:0]  o_word_number,
    input wire logic        o_final_word
);

    // a digest request held back keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_digest_word) && $stable(o_word_number)))
        else $error("digest request changed while stalled");

    // no new message request is taken while a digest is on offer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while digest pending");

    // digest words follow A, B, C, D back to back
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_final_word) |=>
            (o_valid && (o_word_number == $past(o_word_number) + 2'd1)))
        else $error("digest word sequence broken");

    // final mark on word D only
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_final_word == (o_word_number == md5_pkg::LAST_WORD)))
        else $error("final mark on wrong digest word");

    // after word D the unit goes back to taking message bytes
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_final_word) |=> (o_ready && !o_valid))
        else $error("unit not idle after digest");

endmodule

bind md5_message_digest_unit md5_checker u_md5_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_digest_word (o_digest_word),
    .o_word_number (o_word_number),
    .o_final_word  (o_final_word)
);
`default_nettype wire
